// ===== sv/vn_pkg.sv =====
// Package for the vec3_normalize core: shared constants and the pipeline control type.
// No dependencies; every other file uses it through scoped names.
package vn_pkg;

  localparam int COMP_WIDTH    = 24;
  localparam int OUT_FRAC_BITS = 14;
  localparam int OUT_WIDTH     = 16;
  localparam int NUM_LANES     = 3;

  // Control that every pipeline cell sees.
  typedef struct packed {
    logic adv;  // The whole pipe moves one stage this cycle.
  } ctl_t;

endpackage

// ===== sv/vec3_normalize_core.sv =====
// Top level of the vec3_normalize core: magnitude, square, sum, root and divide pipeline.
// Depends on vn_pkg, vn_sqrt_cell and vn_div_cell.
//
// Usage: one vector beat enters on in_x/in_y/in_z under in_valid/in_stall and one
// result beat leaves on out_unit_x/y/z and out_valid_res under out_valid/out_stall.
// The results are the components divided by the floor square root of the sum of
// squares, in signed fixed point with OUT_FRAC_BITS fraction bits, truncated toward
// zero. A zero vector gives out_valid_res low and all components zero.
// Throughput is one beat per cycle. A beat passes through three front stages, one
// square-root cell per root bit (COMP_WIDTH + 1 cells), one divide cell per quotient
// bit (OUT_FRAC_BITS + 1 cells), and the output register. Each cell settles one bit
// and hands its word on.
// The pipe moves as a whole: when a result waits at the output and out_stall is high,
// every stage holds and in_stall rises in the same cycle; otherwise a new beat is
// taken each cycle even while older beats are still in flight.
// Reset clears all stage valid bits, so the pipe comes up empty with out_valid low;
// data registers are not reset.
module vec3_normalize_core #(
  parameter int COMP_WIDTH    = vn_pkg::COMP_WIDTH,
  parameter int OUT_FRAC_BITS = vn_pkg::OUT_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COMP_WIDTH-1:0]  in_x,
  input  logic signed [COMP_WIDTH-1:0]  in_y,
  input  logic signed [COMP_WIDTH-1:0]  in_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [vn_pkg::OUT_WIDTH-1:0] out_unit_x,
  output logic signed [vn_pkg::OUT_WIDTH-1:0] out_unit_y,
  output logic signed [vn_pkg::OUT_WIDTH-1:0] out_unit_z,
  output logic                          out_valid_res
);

  localparam int NL    = vn_pkg::NUM_LANES;
  localparam int OW    = vn_pkg::OUT_WIDTH;
  localparam int MAGW  = COMP_WIDTH;
  localparam int SQW   = 2 * COMP_WIDTH;
  localparam int SUMW  = 2 * COMP_WIDTH + 2;
  localparam int ROOTN = COMP_WIDTH + 1;
  localparam int QW    = OUT_FRAC_BITS + 1;
  localparam int DW    = COMP_WIDTH + OUT_FRAC_BITS + 2;
  localparam int SIDEW = NL * MAGW + NL;
  localparam int SW    = OUT_FRAC_BITS + 2;
  localparam int EW    = (SW > OW) ? SW : OW;

  vn_pkg::ctl_t ctl;

  // The pipe advances unless a finished result is held back by the receiver.
  assign ctl.adv  = !out_valid || !out_stall;
  assign in_stall = !ctl.adv;

  // Front stage: sign and magnitude of each component.
  logic [NL-1:0][COMP_WIDTH-1:0] comp;
  logic [NL-1:0][MAGW-1:0]       mag_nxt;
  logic [NL-1:0]                 neg_nxt;

  assign comp[0] = in_x;
  assign comp[1] = in_y;
  assign comp[2] = in_z;

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      neg_nxt[l] = comp[l][COMP_WIDTH-1];
      mag_nxt[l] = neg_nxt[l] ? (~comp[l] + MAGW'(1)) : comp[l];
    end
  end

  logic                    s1_valid_r;
  logic [NL-1:0][MAGW-1:0] s1_mag_r;
  logic [NL-1:0]           s1_neg_r;
  logic                    s2_valid_r;
  logic [NL-1:0][SQW-1:0]  s2_sq_r;
  logic [NL-1:0][MAGW-1:0] s2_mag_r;
  logic [NL-1:0]           s2_neg_r;
  logic                    s3_valid_r;
  logic [SUMW-1:0]         s3_sum_r;
  logic [NL-1:0][MAGW-1:0] s3_mag_r;
  logic [NL-1:0]           s3_neg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else if (ctl.adv) begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  // One multiplier per lane in the square stage, then a single three-way add.
  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      s1_mag_r <= mag_nxt;
      s1_neg_r <= neg_nxt;
      for (int l = 0; l < NL; l++) begin
        s2_sq_r[l] <= SQW'(s1_mag_r[l]) * SQW'(s1_mag_r[l]);
      end
      s2_mag_r <= s1_mag_r;
      s2_neg_r <= s1_neg_r;
      s3_sum_r <= SUMW'(s2_sq_r[0]) + SUMW'(s2_sq_r[1]) + SUMW'(s2_sq_r[2]);
      s3_mag_r <= s2_mag_r;
      s3_neg_r <= s2_neg_r;
    end
  end

  // Square-root chain: each cell settles one root bit, highest first.
  logic                  sq_valid_w [0:ROOTN];
  logic [SUMW-1:0]       sq_rem_w   [0:ROOTN];
  logic [SUMW-1:0]       sq_root_w  [0:ROOTN];
  logic [SIDEW-1:0]      sq_side_w  [0:ROOTN];

  assign sq_valid_w[0] = s3_valid_r;
  assign sq_rem_w[0]   = s3_sum_r;
  assign sq_root_w[0]  = '0;
  assign sq_side_w[0]  = {s3_neg_r, s3_mag_r};

  for (genvar k = 0; k < ROOTN; k++) begin : g_sqrt
    vn_sqrt_cell #(
      .SUMW  (SUMW),
      .SIDEW (SIDEW),
      .SHIFT (2 * (ROOTN - 1 - k))
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .valid_i (sq_valid_w[k]),
      .rem_i   (sq_rem_w[k]),
      .root_i  (sq_root_w[k]),
      .side_i  (sq_side_w[k]),
      .valid_o (sq_valid_w[k+1]),
      .rem_o   (sq_rem_w[k+1]),
      .root_o  (sq_root_w[k+1]),
      .side_o  (sq_side_w[k+1])
    );
  end

  // Division chain: the scaled magnitude is divided by the length, one quotient
  // bit per cell from the top down. The quotient never exceeds 2^OUT_FRAC_BITS.
  logic [NL-1:0][MAGW-1:0] sq_mag;
  logic                    dv_valid_w [0:QW];
  logic [ROOTN-1:0]        dv_len_w   [0:QW];
  logic [NL-1:0][DW-1:0]   dv_num_w   [0:QW];
  logic [NL-1:0][QW-1:0]   dv_q_w     [0:QW];
  logic [NL-1:0]           dv_neg_w   [0:QW];

  assign sq_mag        = sq_side_w[ROOTN][NL*MAGW-1:0];
  assign dv_valid_w[0] = sq_valid_w[ROOTN];
  assign dv_len_w[0]   = sq_root_w[ROOTN][ROOTN-1:0];
  assign dv_neg_w[0]   = sq_side_w[ROOTN][SIDEW-1:NL*MAGW];

  for (genvar l = 0; l < NL; l++) begin : g_num
    assign dv_num_w[0][l] = DW'(sq_mag[l]) << OUT_FRAC_BITS;
    assign dv_q_w[0][l]   = '0;
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    vn_div_cell #(
      .DW   (DW),
      .QW   (QW),
      .LW   (ROOTN),
      .BITI (QW - 1 - j)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .valid_i (dv_valid_w[j]),
      .len_i   (dv_len_w[j]),
      .num_i   (dv_num_w[j]),
      .q_i     (dv_q_w[j]),
      .neg_i   (dv_neg_w[j]),
      .valid_o (dv_valid_w[j+1]),
      .len_o   (dv_len_w[j+1]),
      .num_o   (dv_num_w[j+1]),
      .q_o     (dv_q_w[j+1]),
      .neg_o   (dv_neg_w[j+1])
    );
  end

  // Output register: apply the signs, wrap to the port width, and force a zero
  // vector to an invalid all-zero beat.
  logic                      len_zero;
  logic signed [SW-1:0]      qs   [NL];
  logic signed [EW-1:0]      qext [NL];
  logic [NL-1:0][OW-1:0]     unit_nxt;
  logic                      out_valid_r;
  logic [NL-1:0][OW-1:0]     unit_r;
  logic                      valid_res_r;

  assign len_zero = (dv_len_w[QW] == '0);

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      qs[l]   = dv_neg_w[QW][l] ? -$signed({1'b0, dv_q_w[QW][l]})
                                :  $signed({1'b0, dv_q_w[QW][l]});
      qext[l] = EW'(qs[l]);
      unit_nxt[l] = len_zero ? '0 : qext[l][OW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.adv) begin
      out_valid_r <= dv_valid_w[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      unit_r      <= unit_nxt;
      valid_res_r <= !len_zero;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_unit_x    = unit_r[0];
  assign out_unit_y    = unit_r[1];
  assign out_unit_z    = unit_r[2];
  assign out_valid_res = valid_res_r;

  // A zero-vector result must carry all-zero components.
  a_zero_vec: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_valid_res) |-> (unit_r == '0))
    else $error("zero-vector result has nonzero components");

  // The input side is only held back by a waiting, stalled result.
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a stalled output");

  // The pipe comes out of reset empty.
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("output valid right after reset");

  // A held result keeps the pipe frozen, so the front stage does not move either.
  a_front_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(s1_valid_r))
    else $error("front stage moved while the output was stalled");

endmodule

// ===== sv/vn_sqrt_cell.sv =====
// One cell of the square-root chain: settles one bit of the floor root.
// Depends on vn_pkg for the pipeline control type.
module vn_sqrt_cell #(
  parameter int SUMW  = 50,
  parameter int SIDEW = 75,
  parameter int SHIFT = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  vn_pkg::ctl_t         ctl,
  input  logic                 valid_i,
  input  logic [SUMW-1:0]      rem_i,
  input  logic [SUMW-1:0]      root_i,
  input  logic [SIDEW-1:0]     side_i,
  output logic                 valid_o,
  output logic [SUMW-1:0]      rem_o,
  output logic [SUMW-1:0]      root_o,
  output logic [SIDEW-1:0]     side_o
);

  localparam logic [SUMW-1:0] BIT = SUMW'(1) << SHIFT;

  logic            valid_r;
  logic [SUMW-1:0] rem_r, rem_nxt;
  logic [SUMW-1:0] root_r, root_nxt;
  logic [SIDEW-1:0] side_r;
  logic [SUMW-1:0] trial;

  always_comb begin
    trial = root_i + BIT;
    if (rem_i >= trial) begin
      rem_nxt  = rem_i - trial;
      root_nxt = (root_i >> 1) + BIT;
    end else begin
      rem_nxt  = rem_i;
      root_nxt = root_i >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.adv) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      side_r <= side_i;
    end
  end

  assign valid_o = valid_r;
  assign rem_o   = rem_r;
  assign root_o  = root_r;
  assign side_o  = side_r;

endmodule

// ===== sv/vn_div_cell.sv =====
// One cell of the division chain: settles one quotient bit for all three lanes.
// Depends on vn_pkg for the lane count and the pipeline control type.
module vn_div_cell #(
  parameter int DW   = 40,
  parameter int QW   = 15,
  parameter int LW   = 25,
  parameter int BITI = 0
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  vn_pkg::ctl_t                        ctl,
  input  logic                                valid_i,
  input  logic [LW-1:0]                       len_i,
  input  logic [vn_pkg::NUM_LANES-1:0][DW-1:0] num_i,
  input  logic [vn_pkg::NUM_LANES-1:0][QW-1:0] q_i,
  input  logic [vn_pkg::NUM_LANES-1:0]         neg_i,
  output logic                                valid_o,
  output logic [LW-1:0]                       len_o,
  output logic [vn_pkg::NUM_LANES-1:0][DW-1:0] num_o,
  output logic [vn_pkg::NUM_LANES-1:0][QW-1:0] q_o,
  output logic [vn_pkg::NUM_LANES-1:0]         neg_o
);

  logic                                 valid_r;
  logic [LW-1:0]                        len_r;
  logic [vn_pkg::NUM_LANES-1:0][DW-1:0] num_r, num_nxt;
  logic [vn_pkg::NUM_LANES-1:0][QW-1:0] q_r, q_nxt;
  logic [vn_pkg::NUM_LANES-1:0]         neg_r;
  logic [DW-1:0]                        dsh;

  always_comb begin
    dsh = DW'(len_i) << BITI;
    for (int l = 0; l < vn_pkg::NUM_LANES; l++) begin
      num_nxt[l] = num_i[l];
      q_nxt[l]   = q_i[l];
      if (num_i[l] >= dsh) begin
        num_nxt[l]     = num_i[l] - dsh;
        q_nxt[l][BITI] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.adv) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      len_r <= len_i;
      num_r <= num_nxt;
      q_r   <= q_nxt;
      neg_r <= neg_i;
    end
  end

  assign valid_o = valid_r;
  assign len_o   = len_r;
  assign num_o   = num_r;
  assign q_o     = q_r;
  assign neg_o   = neg_r;

endmodule

// ===== verif/vec3_normalize_core_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for vec3_normalize_core: directed vectors, then random ones.
// Depends on vn_pkg and the core; its predictor is written independently of the RTL.
module vec3_normalize_core_test;

  localparam int CW = vn_pkg::COMP_WIDTH;
  localparam int FB = vn_pkg::OUT_FRAC_BITS;
  localparam int OW = vn_pkg::OUT_WIDTH;
  localparam int NUM_RANDOM = 1430;
  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 120;

  // One result beat as it leaves the core.
  typedef struct {
    logic signed [OW-1:0] ux;
    logic signed [OW-1:0] uy;
    logic signed [OW-1:0] uz;
    logic                 ok;
  } unit_vec_t;

  // One row of the directed table. When has_exp is set, the typed-in result is
  // compared against the predictor's, so that a wrong row is noticed as well.
  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    bit                   has_exp;
    unit_vec_t            exp_res;
  } vec_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [CW-1:0] in_x = '0;
  logic signed [CW-1:0] in_y = '0;
  logic signed [CW-1:0] in_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [OW-1:0] out_unit_x;
  logic signed [OW-1:0] out_unit_y;
  logic signed [OW-1:0] out_unit_z;
  logic out_valid_res;

  unit_vec_t pending_units[$];
  vec_row_t  directed_rows[$];
  int        error_count = 0;
  int        results_seen = 0;
  int        zero_vectors = 0;
  int        idle_cycles = 0;
  int        stall_left = 0;

  always #1 clk = ~clk;

  vec3_normalize_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_x(in_x), .in_y(in_y), .in_z(in_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_unit_x(out_unit_x), .out_unit_y(out_unit_y), .out_unit_z(out_unit_z),
    .out_valid_res(out_valid_res)
  );

  // Integer floor square root by the classic digit-by-digit method.
  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned rem;
    longint unsigned root;
    longint unsigned bitv;
    rem = v;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // Predicts the unit vector: each magnitude scaled by 2^FB over the floor
  // length, truncated toward zero, and the sign put back afterward.
  function automatic unit_vec_t normalize_vec(logic signed [CW-1:0] x,
                                              logic signed [CW-1:0] y,
                                              logic signed [CW-1:0] z);
    unit_vec_t       r;
    longint unsigned mag[3];
    bit              neg[3];
    logic signed [CW-1:0] c[3];
    longint unsigned sum;
    longint unsigned len;
    longint unsigned q;
    logic [OW-1:0]   w[3];
    c[0] = x;
    c[1] = y;
    c[2] = z;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = c[i][CW-1];
      mag[i] = neg[i] ? (64'd1 << CW) - longint'({1'b0, c[i]}) + 0 : longint'(c[i]);
      if (neg[i]) mag[i] = (64'd1 << CW) - {40'd0, c[i]};
      sum += mag[i] * mag[i];
    end
    len = floor_root(sum);
    if (len == 0) begin
      r.ux = '0;
      r.uy = '0;
      r.uz = '0;
      r.ok = 1'b0;
      return r;
    end
    for (int i = 0; i < 3; i++) begin
      q = (mag[i] << FB) / len;
      if (neg[i]) q = 64'd0 - q;
      w[i] = q[OW-1:0];
    end
    r.ux = w[0];
    r.uy = w[1];
    r.uz = w[2];
    r.ok = 1'b1;
    return r;
  endfunction

  function automatic unit_vec_t unit_of(int ux, int uy, int uz, bit ok);
    unit_vec_t r;
    r.ux = OW'(ux);
    r.uy = OW'(uy);
    r.uz = OW'(uz);
    r.ok = ok;
    return r;
  endfunction

  function automatic vec_row_t row(int x, int y, int z, bit has_exp, unit_vec_t e);
    vec_row_t r;
    r.x = CW'(x);
    r.y = CW'(y);
    r.z = CW'(z);
    r.has_exp = has_exp;
    r.exp_res = e;
    return r;
  endfunction

  // Mostly short gaps, now and then a long one, and often none at all.
  function automatic int gap_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Random component: full range, tiny values, or extremes, so small lengths
  // (where truncation matters most) and huge ones both show up.
  function automatic logic signed [CW-1:0] rand_comp();
    int pick;
    logic signed [CW-1:0] v;
    pick = $urandom_range(0, 9);
    case (pick)
      0: v = '0;
      1: v = CW'($urandom_range(0, 8)) - CW'(4);
      2: v = $urandom_range(0, 1) ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      3: v = CW'($urandom_range(0, 4095)) - CW'(2048);
      default: v = CW'($urandom());
    endcase
    return v;
  endfunction

  function automatic unit_vec_t cap(unit_vec_t e, vec_row_t r);
    unit_vec_t p;
    p = normalize_vec(r.x, r.y, r.z);
    if (r.has_exp && (p.ux !== e.ux || p.uy !== e.uy || p.uz !== e.uz || p.ok !== e.ok)) begin
      $error("table row disagrees with predictor for %0d %0d %0d", r.x, r.y, r.z);
      error_count++;
    end
    return p;
  endfunction

  // Drives one vector beat and holds it until accepted. A held valid stays
  // high across back-to-back beats, so it is assigned once per edge.
  task automatic send_vec(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                          logic signed [CW-1:0] z);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_x <= x;
    in_y <= y;
    in_z <= z;
    pending_units.push_back(normalize_vec(x, y, z));
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Receiver back-pressure: stall runs of random length, mostly short.
  always @(posedge clk) begin
    int gap;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      gap = gap_len();
      out_stall <= (gap > 0);
      stall_left <= (gap > 0) ? gap - 1 : 0;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Result checker: samples at the edge, before any nonblocking update lands.
  always @(posedge clk) begin
    unit_vec_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (pending_units.size() == 0) begin
          $error("result beat with nothing expected");
          error_count++;
        end else begin
          want = pending_units.pop_front();
          if (!want.ok) zero_vectors++;
          if (out_unit_x !== want.ux) begin
            $error("unit_x expected %0d got %0d", want.ux, out_unit_x);
            error_count++;
          end
          if (out_unit_y !== want.uy) begin
            $error("unit_y expected %0d got %0d", want.uy, out_unit_y);
            error_count++;
          end
          if (out_unit_z !== want.uz) begin
            $error("unit_z expected %0d got %0d", want.uz, out_unit_z);
            error_count++;
          end
          if (out_valid_res !== want.ok) begin
            $error("valid_res expected %0b got %0b", want.ok, out_valid_res);
            error_count++;
          end
        end
      end
    end
  end

  // Watchdog: ends the run if no beat moves on either side for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog expired with %0d results outstanding", pending_units.size());
        $display("vec3_normalize_core_test: errors");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    vec_row_t r;
    unit_vec_t e;
    int hold;
    // Directed table: zero vectors, axis-aligned vectors up to the extremes (exact
    // +/-16384), small mixed rows with typed results, and mixed rows left to the predictor.
    directed_rows.push_back(row(0, 0, 0, 1, unit_of(0, 0, 0, 0)));
    directed_rows.push_back(row(1, 0, 0, 1, unit_of(16384, 0, 0, 1)));
    directed_rows.push_back(row(0, -1, 0, 1, unit_of(0, -16384, 0, 1)));
    directed_rows.push_back(row(0, 0, 8388607, 1, unit_of(0, 0, 16384, 1)));
    directed_rows.push_back(row(-8388608, 0, 0, 1, unit_of(-16384, 0, 0, 1)));
    directed_rows.push_back(row(0, -8388608, 0, 1, unit_of(0, -16384, 0, 1)));
    directed_rows.push_back(row(0, 0, -8388608, 1, unit_of(0, 0, -16384, 1)));
    directed_rows.push_back(row(4096, 0, 0, 1, unit_of(16384, 0, 0, 1)));
    directed_rows.push_back(row(3, 4, 0, 1, unit_of(9830, 13107, 0, 1)));
    directed_rows.push_back(row(-3, 0, -4, 1, unit_of(-9830, 0, -13107, 1)));
    directed_rows.push_back(row(1, 1, 1, 1, unit_of(16384, 16384, 16384, 1)));
    directed_rows.push_back(row(-1, -1, -1, 1, unit_of(-16384, -16384, -16384, 1)));
    directed_rows.push_back(row(-8388608, -8388608, -8388608, 0, e));
    directed_rows.push_back(row(8388607, 8388607, 8388607, 0, e));
    directed_rows.push_back(row(8388607, -8388608, 1, 0, e));
    directed_rows.push_back(row(-5592405, 5592405, -1, 0, e));
    directed_rows.push_back(row(1, 2, 2, 0, e));
    directed_rows.push_back(row(0, 0, 0, 1, unit_of(0, 0, 0, 0)));
    directed_rows.push_back(row(12345, -67890, 4096, 0, e));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      r = directed_rows[i];
      void'(cap(r.exp_res, r));
      send_vec(r.x, r.y, r.z);
    end

    for (int n = 0; n < NUM_RANDOM; n++) begin
      send_vec(rand_comp(), rand_comp(), rand_comp());
    end
    in_valid <= 1'b0;

    while (pending_units.size() != 0) @(posedge clk);
    hold = DRAIN_CYCLES;
    repeat (hold) @(posedge clk);

    $display("covered %0d vector beats, %0d of them zero-length",
             results_seen, zero_vectors);
    if (error_count == 0 && !out_valid) begin
      $display("vec3_normalize_core_test: clean");
    end else begin
      if (out_valid) $error("result beat appeared after the last expected one");
      $display("vec3_normalize_core_test: errors");
    end
    $finish;
  end

endmodule
